// ===== design/tss_pkg.sv =====
// Shared codes, defaults and types for the task scheduler with semaphores.
package tss_pkg;

  // Default sizes
  localparam int MAX_TASKS_DEF = 16;
  localparam int NUM_SEMS_DEF  = 8;
  localparam int ID_BITS_DEF   = 8;

  // Fixed field widths
  localparam int FUNC_W   = 3;
  localparam int TID_W    = 8;
  localparam int SIDX_W   = 3;
  localparam int STATUS_W = 3;
  localparam int RID_W    = 8;
  localparam int COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Event codes
  localparam logic [FUNC_W-1:0] FN_CREATE   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DISPATCH = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WAIT     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FINISH   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_POST     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOCUR   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd5;

  // Per-cell control of a queue chain
  typedef struct packed {
    logic load;   // take the pushed id
    logic shift;  // take the right neighbor's id
  } tss_cell_ctl_t;

endpackage

// ===== design/tss_qcell.sv =====
// One storage cell of a shifting queue chain.
module tss_qcell
  import tss_pkg::*;
#(
  parameter int W = ID_BITS_DEF
) (
  input  logic          clk,
  input  tss_cell_ctl_t ctl,
  input  logic [W-1:0]  din,
  input  logic [W-1:0]  right_in,
  output logic [W-1:0]  q
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  // load wins over shift when a push lands on the slot freed by a pop
  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = din;
    end else if (ctl.shift) begin
      data_nxt = right_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== design/tss_queue.sv =====
// FIFO built as a row of cells; the head always sits in cell 0 and a pop shifts the row.
module tss_queue
  import tss_pkg::*;
#(
  parameter int DEPTH = MAX_TASKS_DEF,
  parameter int W     = ID_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic         pop,
  input  logic [W-1:0] din,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);

  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [W-1:0]      cell_q [DEPTH];

  // occupancy count
  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tss_cell_ctl_t ctl;
    logic [W-1:0]  right_in;

    always_comb begin
      ctl.shift = pop;
      if (pop) begin
        ctl.load = push && (fill_r == FILL_W'(i + 1));
      end else begin
        ctl.load = push && (fill_r == FILL_W'(i));
      end
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = cell_q[i];
    end else begin : g_mid
      assign right_in = cell_q[i+1];
    end

    tss_qcell #(.W(W)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .din      (din),
      .right_in (right_in),
      .q        (cell_q[i])
    );
  end

  assign head  = cell_q[0];
  assign empty = (fill_r == '0);
  assign full  = (fill_r == FILL_W'(DEPTH));

endmodule

// ===== design/task_scheduler_semaphore_top.sv =====
// Top level: round-robin task scheduler with ready/wait queues and counting semaphores.
//
//   channel  dir  tdata (low bit up)                         tuser
//   in_      in   task_id[7:0], sem_index[10:8], pad[15:11]  func[2:0]
//   out_     out  result_id[7:0], woke[8], count_after[24:9] status[2:0]
//
// One event per cycle: an accepted beat is resolved in the cycle it arrives and its
// result beat shows in the output register on the next cycle. The queues are cell
// rows whose head is cell 0, so a pop or push is one shift or load of the row.
// in_tready is high whenever the output register is empty or being drained.
// rst_n (synchronous) empties both queues, clears all semaphore counts and the
// current task; queue cells hold no reset value.
module task_scheduler_semaphore_top
  import tss_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int NUM_SEMS  = NUM_SEMS_DEF,
  parameter int ID_BITS   = ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // task_id[7:0], sem_index[10:8], zero pad
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_id[7:0], woke[8], count_after[24:9], zero pad
  output logic [2:0]  out_tuser   // status[2:0]
);

  localparam int SEM_IW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

  logic                in_fire;
  logic [FUNC_W-1:0]   func;
  logic [ID_BITS-1:0]  tid;
  logic [SIDX_W-1:0]   sidx_raw;
  logic [SIDX_W-1:0]   sidx_mod;
  logic [SEM_IW-1:0]   sidx;

  // current task
  logic [ID_BITS-1:0]  run_id_r, run_id_nxt;
  logic                run_v_r, run_v_nxt;
  logic                blk_r, blk_nxt;

  // semaphores
  logic [COUNT_W-1:0]  sem_r [NUM_SEMS];
  logic [COUNT_W-1:0]  sem_cur;
  logic [COUNT_W-1:0]  sem_new;
  logic                sem_we;

  // queues
  logic                rq_push, rq_pop, rq_empty, rq_full;
  logic [ID_BITS-1:0]  rq_din, rq_head;
  logic                wq_push, wq_pop, wq_empty, wq_full;
  logic [ID_BITS-1:0]  wq_head;

  // result
  logic [STATUS_W-1:0] st;
  logic [ID_BITS-1:0]  rid;
  logic                woke;
  logic [COUNT_W-1:0]  cnt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [RID_W-1:0]    out_rid_r;
  logic                out_woke_r;
  logic [COUNT_W-1:0]  out_cnt_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign func     = in_tuser;
  assign tid      = ID_BITS'(in_tdata[7:0]);
  assign sidx_raw = in_tdata[10:8];

  // semaphore index modulo NUM_SEMS (a few narrow subtract steps)
  always_comb begin
    sidx_mod = sidx_raw;
    for (int k = 0; k < 8; k++) begin
      if (32'(sidx_mod) >= NUM_SEMS) begin
        sidx_mod = sidx_mod - SIDX_W'(NUM_SEMS);
      end
    end
  end
  assign sidx    = SEM_IW'(sidx_mod);
  assign sem_cur = sem_r[sidx];

  // event decode
  always_comb begin
    st         = ST_OK;
    rid        = '0;
    woke       = 1'b0;
    cnt        = '0;
    sem_new    = sem_cur;
    sem_we     = 1'b0;
    rq_push    = 1'b0;
    rq_pop     = 1'b0;
    rq_din     = tid;
    wq_push    = 1'b0;
    wq_pop     = 1'b0;
    run_id_nxt = run_id_r;
    run_v_nxt  = run_v_r;
    blk_nxt    = blk_r;
    case (func)
      FN_CREATE: begin
        if (rq_full) begin
          st = ST_FULL;
        end else begin
          rq_push = 1'b1;
        end
      end
      FN_DISPATCH: begin
        if (run_v_r) begin
          st = ST_BUSY;
        end else if (rq_empty) begin
          st = ST_EMPTY;
        end else begin
          rq_pop     = 1'b1;
          run_id_nxt = rq_head;
          run_v_nxt  = 1'b1;
          blk_nxt    = 1'b0;
          rid        = rq_head;
        end
      end
      FN_WAIT: begin
        if (!run_v_r) begin
          st = ST_NOCUR;
        end else if (blk_r) begin
          st = ST_BLOCKED;
        end else if (sem_cur == '0) begin
          blk_nxt = 1'b1;
          st      = ST_BLOCKED;
        end else begin
          sem_new = sem_cur - COUNT_W'(1);
          sem_we  = 1'b1;
        end
        cnt = sem_new;
      end
      FN_FINISH: begin
        if (!run_v_r) begin
          st = ST_NOCUR;
        end else if (blk_r ? wq_full : rq_full) begin
          st = ST_FULL;
        end else begin
          wq_push   = blk_r;
          rq_push   = !blk_r;
          rq_din    = run_id_r;
          rid       = run_id_r;
          run_v_nxt = 1'b0;
          blk_nxt   = 1'b0;
        end
      end
      FN_POST: begin
        if (sem_cur != COUNT_MAX) begin
          sem_new = sem_cur + COUNT_W'(1);
          sem_we  = 1'b1;
        end
        if (!wq_empty) begin
          if (rq_full) begin
            st = ST_FULL;
          end else begin
            wq_pop  = 1'b1;
            rq_push = 1'b1;
            rq_din  = wq_head;
            rid     = wq_head;
            woke    = 1'b1;
          end
        end
        cnt = sem_new;
      end
      default: begin
      end
    endcase
  end

  // current task and semaphore registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_id_r <= '0;
      run_v_r  <= 1'b0;
      blk_r    <= 1'b0;
      for (int k = 0; k < NUM_SEMS; k++) begin
        sem_r[k] <= '0;
      end
    end else if (in_fire) begin
      run_id_r <= run_id_nxt;
      run_v_r  <= run_v_nxt;
      blk_r    <= blk_nxt;
      if (sem_we) begin
        sem_r[sidx] <= sem_new;
      end
    end
  end

  // ready and wait queues
  tss_queue #(.DEPTH(MAX_TASKS), .W(ID_BITS)) u_ready_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_fire && rq_push),
    .pop   (in_fire && rq_pop),
    .din   (rq_din),
    .head  (rq_head),
    .empty (rq_empty),
    .full  (rq_full)
  );

  tss_queue #(.DEPTH(MAX_TASKS), .W(ID_BITS)) u_wait_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_fire && wq_push),
    .pop   (in_fire && wq_pop),
    .din   (run_id_r),
    .head  (wq_head),
    .empty (wq_empty),
    .full  (wq_full)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= st;
      out_rid_r    <= RID_W'(rid);
      out_woke_r   <= woke;
      out_cnt_r    <= cnt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_woke_r, out_rid_r};

endmodule

// ===== design/tss_checker.sv =====
// Port-level checks for the task scheduler, bound to its top level.
module tss_checker
  import tss_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // every accepted event yields a result beat on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted event gave no result beat");

  // a wake-up is always a successful post
  a_woke_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tuser == ST_OK && out_tdata[31:25] == 7'd0)
    else $error("woke set with a failing status");

  // status stays within its defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ST_OK || out_tuser == ST_EMPTY || out_tuser == ST_BLOCKED ||
                   out_tuser == ST_FULL || out_tuser == ST_NOCUR || out_tuser == ST_BUSY)
    else $error("undefined status code");

endmodule

bind task_scheduler_semaphore_top tss_checker u_tss_checker (.*);

// ===== verif/task_scheduler_semaphore_checker.sv =====
// Scoreboard for the task scheduler: predicts each event's result beat and compares it.
`timescale 1ns / 1ps
module task_scheduler_semaphore_checker
  import tss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,      // task_id[7:0], sem_index[10:8], zero pad
  input  logic [2:0]  in_tuser,      // func[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,     // result_id[7:0], woke[8], count_after[24:9], zero pad
  input  logic [2:0]  out_tuser,     // status[2:0]
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output logic [7:0]  status_seen
);

  localparam logic [TID_W-1:0] ID_MASK = TID_W'((1 << ID_BITS_DEF) - 1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RID_W-1:0]    rid;
    logic                woke;
    logic [COUNT_W-1:0]  count;
  } sched_result_t;

  // Mirror of the scheduler state
  logic [TID_W-1:0]   ready_ids[$];
  logic [TID_W-1:0]   waiting_ids[$];
  logic [COUNT_W-1:0] sem_count[NUM_SEMS_DEF];
  logic [TID_W-1:0]   cur_id;
  logic               cur_valid;
  logic               cur_blocked;

  sched_result_t      expected_results[$];

  // Applies one event to the mirrored state and returns the beat it should produce
  function automatic sched_result_t schedule_event(logic [2:0] fn, logic [7:0] tid,
                                                   logic [2:0] sidx);
    sched_result_t    r;
    int               s;
    logic [TID_W-1:0] id;
    r  = '0;
    s  = sidx % NUM_SEMS_DEF;
    id = tid & ID_MASK;
    case (fn)
      FN_CREATE: begin
        if (ready_ids.size() >= MAX_TASKS_DEF) r.status = ST_FULL;
        else ready_ids.push_back(id);
      end
      FN_DISPATCH: begin
        if (cur_valid) begin
          r.status = ST_BUSY;
        end else if (ready_ids.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          cur_id      = ready_ids.pop_front();
          cur_valid   = 1'b1;
          cur_blocked = 1'b0;
          r.rid       = cur_id;
        end
      end
      FN_WAIT: begin
        if (!cur_valid) begin
          r.status = ST_NOCUR;
        end else if (cur_blocked) begin
          r.status = ST_BLOCKED;
        end else if (sem_count[s] == 0) begin
          cur_blocked = 1'b1;
          r.status    = ST_BLOCKED;
        end else begin
          sem_count[s] = sem_count[s] - 1'b1;
        end
        r.count = sem_count[s];
      end
      FN_FINISH: begin
        // blocked task goes to the wait queue, a running one back to ready
        if (!cur_valid) begin
          r.status = ST_NOCUR;
        end else if (cur_blocked ? (waiting_ids.size() >= MAX_TASKS_DEF)
                                 : (ready_ids.size() >= MAX_TASKS_DEF)) begin
          r.status = ST_FULL;
        end else begin
          if (cur_blocked) waiting_ids.push_back(cur_id);
          else ready_ids.push_back(cur_id);
          r.rid       = cur_id;
          cur_valid   = 1'b0;
          cur_blocked = 1'b0;
        end
      end
      FN_POST: begin
        if (sem_count[s] != COUNT_MAX) sem_count[s] = sem_count[s] + 1'b1;
        if (waiting_ids.size() != 0) begin
          if (ready_ids.size() >= MAX_TASKS_DEF) begin
            r.status = ST_FULL;
          end else begin
            id = waiting_ids.pop_front();
            ready_ids.push_back(id);
            r.rid  = id;
            r.woke = 1'b1;
          end
        end
        r.count = sem_count[s];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d mismatch: %s", $time, results_seen, msg);
    fail_count++;
  endtask

  // Compare one output beat against the oldest prediction
  task automatic check_result();
    sched_result_t got;
    sched_result_t want;
    got = {out_tuser, out_tdata[7:0], out_tdata[8], out_tdata[24:9]};
    if (expected_results.size() == 0) begin
      report_mismatch("output beat with no event outstanding");
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.rid !== want.rid)
        report_mismatch($sformatf("result_id %0h, expected %0h", got.rid, want.rid));
      if (got.woke !== want.woke)
        report_mismatch($sformatf("woke %0b, expected %0b", got.woke, want.woke));
      if (got.count !== want.count)
        report_mismatch($sformatf("count_after %0d, expected %0d", got.count, want.count));
    end
    if (got.status < 8) status_seen[got.status] <= 1'b1;
    results_seen++;
  endtask

  // Beat monitor: output side first, its event was queued on an earlier edge
  always @(posedge clk) begin
    if (!rst_n) begin
      ready_ids.delete();
      waiting_ids.delete();
      expected_results.delete();
      for (int i = 0; i < NUM_SEMS_DEF; i++) sem_count[i] = '0;
      cur_id      = '0;
      cur_valid   = 1'b0;
      cur_blocked = 1'b0;
      status_seen <= '0;
      pending     <= 0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready)
        expected_results.push_back(schedule_event(in_tuser, in_tdata[7:0], in_tdata[10:8]));
      pending <= expected_results.size();
    end
  end

endmodule

// ===== verif/task_scheduler_semaphore_top_test.sv =====
// Testbench top for the task scheduler: clock, reset, event stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module task_scheduler_semaphore_top_test;
  import tss_pkg::*;

  // Cycles with no beat on either side before the run is declared hung. The slowest
  // legal stretches come from random gaps and stalls at 50 percent.
  localparam int WATCHDOG_LIMIT = 10000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // task_id[7:0], sem_index[10:8], zero pad
  logic [2:0]  in_tuser;    // func[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;   // result_id[7:0], woke[8], count_after[24:9], zero pad
  logic [2:0]  out_tuser;   // status[2:0]

  int          fail_count;
  int          pending;
  int          results_seen;
  logic [7:0]  status_seen;

  int          send_idle_pct;
  int          stall_pct;
  int          events_sent;
  int          quiet_cycles = 0;

  task_scheduler_semaphore_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  task_scheduler_semaphore_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .status_seen  (status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result-side backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Hang detection
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Drive one event beat, with optional leading gap, and wait for acceptance
  task automatic send_event(logic [2:0] fn, logic [7:0] tid, logic [2:0] sidx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {5'b0, sidx, tid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    events_sent++;
  endtask

  // Hold off until every outstanding result beat has been seen
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_tid();
    rand_tid = $urandom_range(255);
  endfunction

  // Mostly the two low semaphores so counts go up and down; now and then any
  function automatic logic [2:0] rand_sem();
    if ($urandom_range(3) == 0) rand_sem = $urandom_range(7);
    else rand_sem = $urandom_range(1);
  endfunction

  // One scheduler scenario: a task run, a create burst, a post burst or a random beat
  task automatic random_scenario(int w_run, int w_create, int w_post, int w_noise);
    int         pick;
    logic [2:0] fn;
    pick = $urandom_range(w_run + w_create + w_post + w_noise - 1);
    if (pick < w_run) begin
      send_event(FN_DISPATCH, rand_tid(), rand_sem());
      repeat ($urandom_range(2)) send_event(FN_WAIT, rand_tid(), rand_sem());
      send_event(FN_FINISH, rand_tid(), rand_sem());
    end else if (pick < w_run + w_create) begin
      repeat ($urandom_range(1, 4)) send_event(FN_CREATE, rand_tid(), rand_sem());
    end else if (pick < w_run + w_create + w_post) begin
      repeat ($urandom_range(1, 3)) send_event(FN_POST, rand_tid(), rand_sem());
    end else begin
      fn = $urandom_range(7);
      send_event(fn, rand_tid(), $urandom_range(7));
    end
  endtask

  task automatic run_phase(int send_pct, int stall, int num_events,
                           int w_run, int w_create, int w_post, int w_noise);
    int stop_at;
    stop_at       = events_sent + num_events;
    send_idle_pct = send_pct;
    stall_pct     = stall;
    while (events_sent < stop_at) random_scenario(w_run, w_create, w_post, w_noise);
    drain_results();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = FN_CREATE;
    send_idle_pct = 0;
    stall_pct     = 0;
    events_sent   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queues, no current task, block and wake, busy, spare codes
    send_event(FN_DISPATCH, 8'h00, 3'd0);   // ready queue empty
    send_event(FN_WAIT,     8'h00, 3'd3);   // no current task
    send_event(FN_FINISH,   8'h00, 3'd0);   // no current task
    send_event(FN_POST,     8'h00, 3'd7);   // post with nobody waiting
    send_event(FN_CREATE,   8'hFF, 3'd0);
    send_event(FN_CREATE,   8'h00, 3'd0);
    send_event(FN_CREATE,   8'hA5, 3'd0);
    send_event(FN_DISPATCH, 8'h00, 3'd0);
    send_event(FN_DISPATCH, 8'h00, 3'd0);   // busy
    send_event(FN_WAIT,     8'h00, 3'd7);   // takes the count
    send_event(FN_WAIT,     8'h00, 3'd7);   // count zero, blocks
    send_event(FN_WAIT,     8'h00, 3'd7);   // already blocked
    send_event(FN_DISPATCH, 8'h00, 3'd0);   // busy while blocked
    send_event(FN_FINISH,   8'h00, 3'd0);   // into the wait queue
    send_event(FN_POST,     8'h00, 3'd2);   // wakes the waiter
    send_event(FN_POST,     8'h00, 3'd2);
    for (int c = int'(FN_POST) + 1; c < 8; c++) send_event(c[2:0], 8'h5A, 3'd5);
    send_event(FN_DISPATCH, 8'h00, 3'd0);
    send_event(FN_FINISH,   8'h00, 3'd0);   // back to ready
    send_event(FN_CREATE,   8'h3C, 3'd7);
    drain_results();

    // Random phases: balanced, wait-queue filling, ready-queue filling, draining
    run_phase(0,  0,  450, 4, 3, 2, 1);
    run_phase(0,  50, 450, 6, 3, 0, 1);
    run_phase(50, 0,  450, 2, 6, 2, 1);
    run_phase(20, 20, 450, 4, 2, 5, 1);

    // Build up one semaphore, then take from it
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (12) send_event(FN_POST, rand_tid(), 3'd5);
    send_event(FN_CREATE,   rand_tid(), 3'd5);
    send_event(FN_DISPATCH, rand_tid(), 3'd5);
    send_event(FN_WAIT,     rand_tid(), 3'd5);
    send_event(FN_FINISH,   rand_tid(), 3'd5);

    drain_results();
    repeat (5) @(posedge clk);

    $display("Ran %0d scheduler events, %0d result beats checked, over four handshake",
             events_sent, results_seen);
    $display("phases and a semaphore post burst; status codes seen (bit per code): %b",
             status_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tss_pkg.sv
design/tss_qcell.sv
design/tss_queue.sv
design/task_scheduler_semaphore_top.sv
design/tss_checker.sv
verif/task_scheduler_semaphore_checker.sv
verif/task_scheduler_semaphore_top_test.sv
